// ===== rtl/rbfnc_pkg.sv =====
// Shared types, codes and constants of the RBF network classifier.
`timescale 1ns / 1ps
package rbfnc_pkg;
	localparam int MAX_CENTERS_DEF = 32;
	localparam int MAX_FEATURES_DEF = 16;

	localparam logic [1:0] CMD_CENTER = 2'd0;
	localparam logic [1:0] CMD_WEIGHT = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;

	localparam logic [1:0] CFG_CENTER_COUNT     = 2'd0;
	localparam logic [1:0] CFG_FEATURE_COUNT    = 2'd1;
	localparam logic [1:0] CFG_INV_TWO_SIGMA_SQ = 2'd2;
	localparam logic [1:0] CFG_BIAS             = 2'd3;

	localparam logic [5:0]  CENTER_COUNT_RST  = 6'd32;
	localparam logic [4:0]  FEATURE_COUNT_RST = 5'd2;
	localparam logic [31:0] INV_SIGMA_RST     = 32'd32768;
	localparam logic [31:0] BIAS_RST          = 32'd0;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam logic [30:0] INV_E_Q32 = 31'd1580030169;

	typedef struct packed {
		logic [1:0]         command;
		logic [4:0]         center_index;
		logic [3:0]         feature_index;
		logic signed [15:0] coordinate;
		logic signed [31:0] weight_value;
	} item_t;

	typedef struct packed {
		logic [16:0] probability;
		logic        predicted_class;
	} result_t;

	typedef enum logic [1:0] {
		OP_CENTER = 2'd0,
		OP_WEIGHT = 2'd1,
		OP_SAMPLE = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [4:0]         center_index;
		logic [3:0]         feature_index;
		logic signed [15:0] coordinate;
		logic signed [31:0] weight_value;
		logic               first;
		logic               last;
	} job_t;

	typedef struct packed {
		logic        start;
		logic [15:0] n;
		logic [31:0] f;
	} exp_req_t;

	typedef struct packed {
		logic        done;
		logic [32:0] value;
	} exp_rsp_t;

	typedef struct packed {
		logic        start;
		logic [49:0] num;
		logic [33:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] quo;
	} div_rsp_t;

	// floor(2^32 / k); the quotient it gives is low by at most one
	function automatic logic [31:0] recip_q32(input logic [3:0] k);
		logic [31:0] r;
		case (k)
			4'd2:    r = 32'd2147483648;
			4'd3:    r = 32'd1431655765;
			4'd4:    r = 32'd1073741824;
			4'd5:    r = 32'd858993459;
			4'd6:    r = 32'd715827882;
			4'd7:    r = 32'd613566756;
			4'd8:    r = 32'd536870912;
			4'd9:    r = 32'd477218588;
			4'd10:   r = 32'd429496729;
			4'd11:   r = 32'd390451572;
			4'd12:   r = 32'd357913941;
			4'd13:   r = 32'd330382099;
			default: r = 32'hFFFF_FFFF;
		endcase
		return r;
	endfunction
endpackage

// ===== rtl/rbfnc_front.sv =====
// Front end: accepts items, drops ignored ones, queues jobs for the back end.
`timescale 1ns / 1ps
module rbfnc_front #(
	parameter int MAX_CENTERS  = rbfnc_pkg::MAX_CENTERS_DEF,
	parameter int MAX_FEATURES = rbfnc_pkg::MAX_FEATURES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  rbfnc_pkg::item_t                     item,
	input  logic [$clog2(MAX_FEATURES+1)-1:0]    nf,
	output logic                                 job_valid,
	output rbfnc_pkg::job_t                      job,
	input  logic                                 job_pop
);
	import rbfnc_pkg::*;

	job_t                jin;
	logic                keep;
	logic                push;
	job_t                q_mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   cnt_q;

	always_comb begin
		keep = 1'b0;
		jin.op = OP_SAMPLE;
		jin.center_index = item.center_index;
		jin.feature_index = item.feature_index;
		jin.coordinate = item.coordinate;
		jin.weight_value = item.weight_value;
		jin.first = (item.feature_index == 4'd0);
		jin.last = ((32'(item.feature_index) + 32'd1) == 32'(nf));
		case (item.command)
			CMD_CENTER: begin
				jin.op = OP_CENTER;
				keep = (32'(item.center_index) < MAX_CENTERS) &&
					(32'(item.feature_index) < MAX_FEATURES);
			end
			CMD_WEIGHT: begin
				jin.op = OP_WEIGHT;
				keep = (32'(item.center_index) < MAX_CENTERS);
			end
			CMD_SAMPLE: begin
				jin.op = OP_SAMPLE;
				keep = (32'(item.feature_index) < 32'(nf));
			end
			default: keep = 1'b0;
		endcase
	end

	assign item_stall = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign push = item_valid && !item_stall && keep;
	assign job_valid = (cnt_q != '0);
	assign job = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_ptr_q] <= jin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (job_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !job_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && job_pop) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ===== rtl/rbfnc_exp.sv =====
// Iterative exp(-t) unit: Taylor series of the fraction, then scaling by 1/e.
`timescale 1ns / 1ps
module rbfnc_exp (
	input  logic                clk,
	input  logic                arst_n,
	input  rbfnc_pkg::exp_req_t req,
	output rbfnc_pkg::exp_rsp_t rsp
);
	import rbfnc_pkg::*;

	typedef enum logic [6:0] {
		E_IDLE  = 7'b0000001,
		E_MUL   = 7'b0000010,
		E_RCP   = 7'b0000100,
		E_FIX   = 7'b0001000,
		E_CLAMP = 7'b0010000,
		E_SCALE = 7'b0100000,
		E_DONE  = 7'b1000000
	} exp_state_t;

	exp_state_t         state_q;
	logic [31:0]        f_q;
	logic [31:0]        term_q;
	logic [31:0]        tq_q;
	logic [63:0]        prod_q;
	logic signed [34:0] sum_q;
	logic [3:0]         k_q;
	logic [4:0]         cnt_q;
	logic [32:0]        r_q;

	logic [31:0] q0;
	logic [31:0] rem;
	logic [31:0] qt;

	always_comb begin
		q0 = prod_q[63:32];
		rem = tq_q - 32'(36'(q0) * 36'(k_q));
		qt = (rem >= 32'(k_q)) ? q0 + 32'd1 : q0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			case (state_q)
				E_IDLE: begin
					if (req.start) begin
						if (|req.n[15:5]) begin
							r_q <= '0;
							state_q <= E_DONE;
						end else begin
							f_q <= req.f;
							term_q <= req.f;
							sum_q <= 35'sh1_0000_0000 - $signed({3'b000, req.f});
							k_q <= 4'd2;
							cnt_q <= req.n[4:0];
							state_q <= E_MUL;
						end
					end
				end
				E_MUL: begin
					prod_q <= 64'(term_q) * 64'(f_q);
					state_q <= E_RCP;
				end
				E_RCP: begin
					tq_q <= prod_q[63:32];
					prod_q <= 64'(prod_q[63:32]) * 64'(recip_q32(k_q));
					state_q <= E_FIX;
				end
				E_FIX: begin
					term_q <= qt;
					if (k_q[0]) sum_q <= sum_q - $signed({3'b000, qt});
					else sum_q <= sum_q + $signed({3'b000, qt});
					if (k_q == 4'd13) begin
						state_q <= E_CLAMP;
					end else begin
						k_q <= k_q + 4'd1;
						state_q <= E_MUL;
					end
				end
				E_CLAMP: begin
					if (sum_q[34]) r_q <= '0;
					else if (sum_q > 35'sh1_0000_0000) r_q <= 33'h1_0000_0000;
					else r_q <= sum_q[32:0];
					state_q <= (cnt_q == '0) ? E_DONE : E_SCALE;
				end
				E_SCALE: begin
					r_q <= 33'((64'(r_q) * 64'(INV_E_Q32) + 64'h8000_0000) >> 32);
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) state_q <= E_DONE;
				end
				E_DONE: state_q <= E_IDLE;
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign rsp.done = (state_q == E_DONE);
	assign rsp.value = r_q;
endmodule

// ===== rtl/rbfnc_div.sv =====
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
`timescale 1ns / 1ps
module rbfnc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rbfnc_pkg::div_req_t req,
	output rbfnc_pkg::div_rsp_t rsp
);
	import rbfnc_pkg::*;

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_DONE = 3'b100
	} div_state_t;

	div_state_t  state_q;
	logic [49:0] rem_q;
	logic [49:0] dsh_q;
	logic [16:0] quo_q;
	logic [4:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						rem_q <= req.num;
						dsh_q <= 50'(req.den) << 16;
						quo_q <= '0;
						cnt_q <= 5'd16;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (rem_q >= dsh_q) begin
						rem_q <= rem_q - dsh_q;
						quo_q <= {quo_q[15:0], 1'b1};
					end else begin
						quo_q <= {quo_q[15:0], 1'b0};
					end
					dsh_q <= dsh_q >> 1;
					if (cnt_q == '0) state_q <= D_DONE;
					else cnt_q <= cnt_q - 5'd1;
				end
				D_DONE: state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.done = (state_q == D_DONE);
	assign rsp.quo = quo_q;
endmodule

// ===== rtl/rbfnc_back.sv =====
// Back end: tables, distance walk, activations, weighted sum and sigmoid.
`timescale 1ns / 1ps
module rbfnc_back #(
	parameter int MAX_CENTERS  = rbfnc_pkg::MAX_CENTERS_DEF,
	parameter int MAX_FEATURES = rbfnc_pkg::MAX_FEATURES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               job_valid,
	input  rbfnc_pkg::job_t                    job,
	output logic                               job_pop,
	input  logic [$clog2(MAX_CENTERS+1)-1:0]   nc,
	input  logic [31:0]                        inv_two_sigma_sq,
	input  logic signed [31:0]                 bias,
	output logic                               result_valid,
	input  logic                               result_stall,
	output rbfnc_pkg::result_t                 result
);
	import rbfnc_pkg::*;

	localparam int NC_W     = $clog2(MAX_CENTERS+1);
	localparam int AW       = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int CT_DEPTH = MAX_CENTERS * MAX_FEATURES;
	localparam int CT_AW    = (CT_DEPTH > 1) ? $clog2(CT_DEPTH) : 1;
	localparam int SUM_W    = 50 + $clog2(MAX_CENTERS+1);
	localparam int SH_W     = SUM_W - 16;

	typedef enum logic [14:0] {
		ST_IDLE  = 15'h0001,
		ST_WALK  = 15'h0002,
		ST_ARD   = 15'h0004,
		ST_AM0   = 15'h0008,
		ST_AM1   = 15'h0010,
		ST_APR   = 15'h0020,
		ST_AEXP  = 15'h0040,
		ST_AMAC  = 15'h0080,
		ST_AACC  = 15'h0100,
		ST_SUM   = 15'h0200,
		ST_SIG   = 15'h0400,
		ST_SEXP  = 15'h0800,
		ST_SDIV  = 15'h1000,
		ST_SWAIT = 15'h2000,
		ST_OUT   = 15'h4000
	} back_state_t;

	back_state_t state_q;

	logic signed [15:0] ctab_mem [CT_DEPTH];
	logic signed [31:0] wtab_mem [MAX_CENTERS];
	logic [39:0]        dacc_mem [MAX_CENTERS];
	logic [MAX_CENTERS-1:0] dvalid_q;

	logic signed [15:0] ct_rd_q;
	logic signed [31:0] w_rd_q;
	logic [39:0]        dt_rd_q;

	logic signed [15:0] x_q;
	logic [3:0]         fi_q;
	logic               last_q;
	logic [NC_W-1:0]    iss_q;
	logic               v_s1;
	logic [AW-1:0]      c_s1;
	logic               v_s2;
	logic [AW-1:0]      c_s2;
	logic [31:0]        sq_s2;
	logic [39:0]        base_s2;

	logic [NC_W-1:0]          act_c_q;
	logic [39:0]              d_q;
	logic [63:0]              plo_q;
	logic [39:0]              phi_q;
	logic [16:0]              act_q;
	logic signed [49:0]       mac_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [31:0]       s_q;
	logic [32:0]              e_q;
	logic [16:0]              p_q;
	logic                     out_valid_q;
	result_t                  result_q;

	logic                    ct_we;
	logic                    wt_we;
	logic [CT_AW-1:0]        ct_waddr;
	logic [CT_AW-1:0]        ct_raddr;
	logic [AW-1:0]           dacc_raddr;
	logic                    walk_issue;
	logic signed [16:0]      diff;
	logic [40:0]             dsum;
	logic [71:0]             prod;
	logic signed [SUM_W-1:0] q_rnd;
	logic signed [SH_W-1:0]  s_full;
	logic [SH_W-32:0]        s_hi;
	logic signed [31:0]      s_sat;
	logic [31:0]             s_mag;
	logic [33:0]             den;
	exp_req_t                exp_req;
	exp_rsp_t                exp_rsp;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	rbfnc_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (exp_req),
		.rsp    (exp_rsp)
	);

	rbfnc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		job_pop = (state_q == ST_IDLE) && job_valid;
		ct_we = job_pop && (job.op == OP_CENTER);
		wt_we = job_pop && (job.op == OP_WEIGHT);
		ct_waddr = CT_AW'(32'(job.center_index) * MAX_FEATURES + 32'(job.feature_index));
		ct_raddr = CT_AW'(32'(iss_q[AW-1:0]) * MAX_FEATURES + 32'(fi_q));
		walk_issue = (state_q == ST_WALK) && (iss_q < nc);
		dacc_raddr = (state_q == ST_WALK) ? iss_q[AW-1:0] : act_c_q[AW-1:0];
		diff = 17'(x_q) - 17'(ct_rd_q);
		dsum = {1'b0, base_s2} + 41'(sq_s2);
		prod = {8'd0, plo_q} + {phi_q, 32'd0};

		q_rnd = acc_q + SUM_W'(32768);
		s_full = q_rnd[SUM_W-1:16];
		s_hi = s_full[SH_W-1:31];
		if (!s_full[SH_W-1] && (|s_hi)) s_sat = 32'sh7FFF_FFFF;
		else if (s_full[SH_W-1] && !(&s_hi)) s_sat = 32'sh8000_0000;
		else s_sat = s_full[31:0];

		s_mag = s_q[31] ? (32'd0 - s_q) : s_q;
		den = 34'h1_0000_0000 + 34'(e_q);

		exp_req.start = ((state_q == ST_APR) && (inv_two_sigma_sq != '0) &&
			(prod[71:36] == '0)) || (state_q == ST_SIG);
		exp_req.n = (state_q == ST_SIG) ? s_mag[31:16] : {12'd0, prod[35:32]};
		exp_req.f = (state_q == ST_SIG) ? {s_mag[15:0], 16'd0} : prod[31:0];

		div_req.start = (state_q == ST_SDIV);
		div_req.den = den;
		if (s_q[31]) div_req.num = (50'(e_q) << 16) + 50'(den >> 1);
		else div_req.num = (50'd1 << 48) + 50'(den >> 1);
	end

	// tables and accumulators
	always_ff @(posedge clk) begin
		if (ct_we) ctab_mem[ct_waddr] <= job.coordinate;
		ct_rd_q <= ctab_mem[ct_raddr];
	end

	always_ff @(posedge clk) begin
		if (wt_we) wtab_mem[AW'(job.center_index)] <= job.weight_value;
		w_rd_q <= wtab_mem[act_c_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (v_s2) dacc_mem[c_s2] <= dsum[40] ? 40'hFF_FFFF_FFFF : dsum[39:0];
		dt_rd_q <= dacc_mem[dacc_raddr];
	end

	// walk datapath
	always_ff @(posedge clk) begin
		c_s1 <= iss_q[AW-1:0];
		c_s2 <= c_s1;
		sq_s2 <= 32'(34'(diff * diff));
		base_s2 <= dvalid_q[c_s1] ? dt_rd_q : 40'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			dvalid_q <= '0;
			iss_q <= '0;
			act_c_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= walk_issue;
			v_s2 <= v_s1;
			if (v_s2) dvalid_q[c_s2] <= 1'b1;
			if (out_valid_q && !result_stall && (state_q != ST_OUT)) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (job_pop && (job.op == OP_SAMPLE)) begin
						x_q <= job.coordinate;
						fi_q <= job.feature_index;
						last_q <= job.last;
						iss_q <= '0;
						if (job.first) dvalid_q <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_issue) iss_q <= iss_q + 1'b1;
					if ((iss_q == nc) && !v_s1 && !v_s2) begin
						act_c_q <= '0;
						acc_q <= SUM_W'(bias) <<< 16;
						state_q <= last_q ? ST_ARD : ST_IDLE;
					end
				end
				ST_ARD: state_q <= (act_c_q == nc) ? ST_SUM : ST_AM0;
				ST_AM0: begin
					d_q <= dvalid_q[act_c_q[AW-1:0]] ? dt_rd_q : 40'd0;
					plo_q <= 64'(dvalid_q[act_c_q[AW-1:0]] ? dt_rd_q[31:0] : 32'd0) *
						64'(inv_two_sigma_sq);
					state_q <= ST_AM1;
				end
				ST_AM1: begin
					phi_q <= 40'(d_q[39:32]) * 40'(inv_two_sigma_sq);
					state_q <= ST_APR;
				end
				ST_APR: begin
					if (inv_two_sigma_sq == '0) begin
						act_q <= 17'h1_0000;
						state_q <= ST_AMAC;
					end else if (prod[71:36] != '0) begin
						act_q <= '0;
						state_q <= ST_AMAC;
					end else begin
						state_q <= ST_AEXP;
					end
				end
				ST_AEXP: begin
					if (exp_rsp.done) begin
						act_q <= 17'((exp_rsp.value + 33'd32768) >> 16);
						state_q <= ST_AMAC;
					end
				end
				ST_AMAC: begin
					mac_q <= $signed({1'b0, act_q}) * w_rd_q;
					state_q <= ST_AACC;
				end
				ST_AACC: begin
					acc_q <= acc_q + SUM_W'(mac_q);
					act_c_q <= act_c_q + 1'b1;
					state_q <= ST_ARD;
				end
				ST_SUM: begin
					s_q <= s_sat;
					state_q <= ST_SIG;
				end
				ST_SIG: state_q <= ST_SEXP;
				ST_SEXP: begin
					if (exp_rsp.done) begin
						e_q <= exp_rsp.value;
						state_q <= ST_SDIV;
					end
				end
				ST_SDIV: state_q <= ST_SWAIT;
				ST_SWAIT: begin
					if (div_rsp.done) begin
						p_q <= div_rsp.quo;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !result_stall) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && (!out_valid_q || !result_stall)) begin
			result_q.probability <= p_q;
			result_q.predicted_class <= !s_q[31];
		end
	end

	assign result_valid = out_valid_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (iss_q <= nc))
		else $error("walk issued past the centre count");
	a_act_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AM0) |-> (act_c_q < nc))
		else $error("activation step past the centre count");
	a_exp_owner: assert property (@(posedge clk) disable iff (!arst_n)
		exp_rsp.done |-> ((state_q == ST_AEXP) || (state_q == ST_SEXP)))
		else $error("exp result with no step waiting for it");
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_SWAIT))
		else $error("divider result with no step waiting for it");
`endif
endmodule

// ===== rtl/rbf_network_classify_top.sv =====
// Top level of the Gaussian RBF network classifier: config registers, front and back ends.
`timescale 1ns / 1ps
// Gaussian RBF network binary classifier, inference only. Items arrive on the item channel
// (valid/stall) and are checked by the front end: centre and weight writes out of range, an
// unknown command and sample features at or beyond the feature count are dropped there; the
// rest wait in a four-entry queue, so the item side keeps flowing while the back end is busy
// until the queue is full. The back end takes one job at a time. A sample feature walks every
// active centre through the distance pipeline, one centre a cycle; feature zero clears the
// distance accumulators first. The feature carrying the last index then runs the activation
// loop, one centre at a time through the shared exp unit, which is skipped where the
// activation is known to be 0 or 1. The sigmoid runs one exp (its series skipped when the
// integer part of |sum| is 32 or more), then a 17-step divider, before the result is
// registered on the result channel, where it waits for the sink; the back end holds only
// when a further result is ready while that one still waits.
// Config writes (index 0 centre_count, 1 feature_count, 2 inv_two_sigma_sq, 3 bias) are always
// ready and must only be made while the block is idle.
module rbf_network_classify_top #(
	parameter int MAX_CENTERS  = rbfnc_pkg::MAX_CENTERS_DEF,
	parameter int MAX_FEATURES = rbfnc_pkg::MAX_FEATURES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  rbfnc_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output rbfnc_pkg::result_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import rbfnc_pkg::*;

	localparam int NC_W = $clog2(MAX_CENTERS+1);
	localparam int NF_W = $clog2(MAX_FEATURES+1);

	logic [5:0]         center_count_q;
	logic [4:0]         feature_count_q;
	logic [31:0]        inv_sigma_q;
	logic signed [31:0] bias_q;
	logic [NC_W-1:0]    nc;
	logic [NF_W-1:0]    nf;
	logic               job_valid;
	logic               job_pop;
	job_t               job;

	assign cfg_ready = 1'b1;

	// config registers; a transaction lands when valid and ready meet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_count_q <= CENTER_COUNT_RST;
			feature_count_q <= FEATURE_COUNT_RST;
			inv_sigma_q <= INV_SIGMA_RST;
			bias_q <= BIAS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CENTER_COUNT:     center_count_q <= cfg_data[5:0];
				CFG_FEATURE_COUNT:    feature_count_q <= cfg_data[4:0];
				CFG_INV_TWO_SIGMA_SQ: inv_sigma_q <= cfg_data;
				CFG_BIAS:             bias_q <= cfg_data;
				default:              bias_q <= bias_q;
			endcase
		end
	end

	// counts above the table sizes saturate
	always_comb begin
		if (32'(center_count_q) > MAX_CENTERS) nc = NC_W'(MAX_CENTERS);
		else nc = NC_W'(center_count_q);
		if (32'(feature_count_q) > MAX_FEATURES) nf = NF_W'(MAX_FEATURES);
		else nf = NF_W'(feature_count_q);
	end

	rbfnc_front #(
		.MAX_CENTERS  (MAX_CENTERS),
		.MAX_FEATURES (MAX_FEATURES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.nf         (nf),
		.job_valid  (job_valid),
		.job        (job),
		.job_pop    (job_pop)
	);

	rbfnc_back #(
		.MAX_CENTERS  (MAX_CENTERS),
		.MAX_FEATURES (MAX_FEATURES)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.job_valid        (job_valid),
		.job              (job),
		.job_pop          (job_pop),
		.nc               (nc),
		.inv_two_sigma_sq (inv_sigma_q),
		.bias             (bias_q),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.result           (result)
	);
endmodule

// ===== tb/tb_rbf_network_classify_top.sv =====
// Self-checking testbench of the Gaussian RBF network classifier top level.
`timescale 1ns / 1ps
// Drives items on the valid/stall channel and register writes on the config channel, keeps
// its own fixed-point model of the classifier and compares each result transaction with the
// oldest prediction. A short table of directed rows comes first (empty network, bias extremes,
// ignored items, the zero-sigma case); the tables are then filled completely so that no
// unwritten entry is ever read, and random phases follow, each with its own register setting.
module tb_rbf_network_classify_top;
	import rbfnc_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int NUM_CTR = 32;
	localparam int NUM_FEAT = 16;
	localparam int ITEM_TARGET = 1350;
	localparam int DRAIN_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 20000000;
	localparam longint unsigned ONE_Q32 = 64'h1_0000_0000;
	localparam longint unsigned DIST_SAT = (64'd1 << 40) - 64'd1;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	rbf_network_classify_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// model state and register copies
	logic signed [15:0] ctr_coord [NUM_CTR][NUM_FEAT];
	logic signed [31:0] ctr_weight [NUM_CTR];
	longint unsigned dist_acc [NUM_CTR];
	logic [5:0] reg_centers = CENTER_COUNT_RST;
	logic [4:0] reg_features = FEATURE_COUNT_RST;
	logic [31:0] reg_inv_sigma = INV_SIGMA_RST;
	logic [31:0] reg_bias = BIAS_RST;

	result_t pending_results [$];
	int errors = 0;
	longint cycles = 0;
	int items_sent = 0;
	bit calm_tx = 0;
	bit calm_rx = 0;
	int stall_left = 0;

	typedef struct {
		bit is_cfg;
		logic [1:0] idx;
		logic [31:0] data;
		item_t it;
		bit known;
		result_t want;
	} step_t;

	step_t steps [$];

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic add_row(input step_t st);
		steps = {steps, st};
	endtask

	// exp(-(n + f/2^32)) in Q.32: truncated Taylor series of the fraction, then 1/e per unit
	function automatic longint unsigned exp_neg_q32(input longint unsigned n,
			input longint unsigned f);
		longint sum;
		longint unsigned term;
		longint unsigned r;
		if (n >= 32)
			return 0;
		sum = longint'(ONE_Q32);
		term = ONE_Q32;
		f = f & 64'hFFFF_FFFF;
		for (int k = 1; k <= 13; k++) begin
			term = (term * f) >> 32;
			term = term / longint'(k);
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > longint'(ONE_Q32))
			sum = longint'(ONE_Q32);
		r = longint'(sum);
		for (longint unsigned k = 0; k < n; k++)
			r = (r * 64'd1580030169 + 64'h8000_0000) >> 32;
		return r;
	endfunction

	// updates the model with one accepted item; returns 1 when it yields a classification
	function automatic bit classify_item(input item_t it, output result_t res);
		int nc;
		int nf;
		longint x;
		longint diff;
		longint unsigned d;
		longint unsigned act;
		longint unsigned prod;
		longint unsigned m;
		longint unsigned e;
		longint unsigned den;
		longint unsigned p;
		longint acc;
		longint wv;
		longint q;
		longint s;
		res = '0;
		nc = reg_centers > NUM_CTR ? NUM_CTR : int'(reg_centers);
		nf = reg_features > NUM_FEAT ? NUM_FEAT : int'(reg_features);
		if (it.command == CMD_CENTER) begin
			ctr_coord[it.center_index][it.feature_index] = it.coordinate;
			return 0;
		end
		if (it.command == CMD_WEIGHT) begin
			ctr_weight[it.center_index] = it.weight_value;
			return 0;
		end
		if (it.command != CMD_SAMPLE || int'(it.feature_index) >= nf)
			return 0;
		if (it.feature_index == 0)
			foreach (dist_acc[c])
				dist_acc[c] = 0;
		x = it.coordinate;
		for (int c = 0; c < nc; c++) begin
			diff = x - longint'(ctr_coord[c][it.feature_index]);
			d = dist_acc[c] + longint'(diff * diff);
			dist_acc[c] = d > DIST_SAT ? DIST_SAT : d;
		end
		if (int'(it.feature_index) != nf - 1)
			return 0;
		acc = longint'($signed(reg_bias)) * 65536;
		for (int c = 0; c < nc; c++) begin
			d = dist_acc[c];
			if (reg_inv_sigma == 0)
				act = 65536;
			else if (d > ((64'd1 << 36) - 64'd1) / longint'(reg_inv_sigma))
				act = 0;
			else begin
				prod = d * longint'(reg_inv_sigma);
				act = (exp_neg_q32(prod >> 32, prod & 64'hFFFF_FFFF) + 64'd32768) >> 16;
			end
			wv = ctr_weight[c];
			acc = acc + longint'(act) * wv;
		end
		// round half up to Q16.16, then saturate
		q = acc + 32768;
		if (q >= 0)
			s = q / 65536;
		else
			s = -((-q + 65535) / 65536);
		if (s > 64'sh7FFF_FFFF)
			s = 64'sh7FFF_FFFF;
		if (s < -64'sh8000_0000)
			s = -64'sh8000_0000;
		m = s >= 0 ? longint'(s) : longint'(-s);
		e = exp_neg_q32(m >> 16, (m & 64'hFFFF) << 16);
		den = ONE_Q32 + e;
		if (s >= 0)
			p = ((64'd1 << 48) + den / 2) / den;
		else
			p = (e * 64'd65536 + den / 2) / den;
		res.probability = p[16:0];
		res.predicted_class = s >= 0;
		return 1;
	endfunction

	function automatic item_t mk_item(input logic [1:0] cmd, input int ci, input int fi,
			input logic [15:0] coord, input logic [31:0] w);
		item_t it;
		it.command = cmd;
		it.center_index = ci[4:0];
		it.feature_index = fi[3:0];
		it.coordinate = coord;
		it.weight_value = w;
		return it;
	endfunction

	function automatic step_t row_cfg(input logic [1:0] idx, input logic [31:0] data);
		step_t st;
		st = '{default: '0};
		st.is_cfg = 1;
		st.idx = idx;
		st.data = data;
		return st;
	endfunction

	function automatic step_t row_item(input item_t it, input bit known = 0,
			input logic [16:0] prob = '0, input logic cls = 0);
		step_t st;
		st = '{default: '0};
		st.it = it;
		st.known = known;
		st.want.probability = prob;
		st.want.predicted_class = cls;
		return st;
	endfunction

	// mostly back to back, sometimes a short gap, now and then a long one
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [15:0] rand_coord();
		if ($urandom_range(0, 3) != 0)
			return 16'($urandom_range(0, 1535) - 768);
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] rand_weight();
		if ($urandom_range(0, 9) < 7)
			return 32'($urandom_range(0, 262143) - 131072);
		return $urandom;
	endfunction

	// one item transaction; valid stays high across back-to-back items
	task automatic send_item(input item_t it, input bit known = 0, input result_t want = '0);
		int gap;
		result_t res;
		gap = pick_gap(calm_tx);
		if (gap > 0) begin
			item_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1;
		item <= it;
		do @(posedge clk); while (item_stall);
		if (classify_item(it, res))
			pending_results = {pending_results, known ? want : res};
	endtask

	// all results in, then enough cycles for writes and non-final features still queued
	task automatic settle();
		item_valid <= 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		settle();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			CFG_CENTER_COUNT:     reg_centers = data[5:0];
			CFG_FEATURE_COUNT:    reg_features = data[4:0];
			CFG_INV_TWO_SIGMA_SQ: reg_inv_sigma = data;
			default:              reg_bias = data;
		endcase
	endtask

	// result side: stall in bursts, calm stretches with none
	always @(posedge clk) begin
		if (!arst_n)
			result_stall <= 0;
		else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1;
		end else if (!calm_rx && $urandom_range(0, 99) < 15) begin
			stall_left <= $urandom_range(0, 9) == 0 ? $urandom_range(20, 80)
				: $urandom_range(0, 2);
			result_stall <= 1;
		end else
			result_stall <= 0;
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0)
				report_mismatch("result transaction with no prediction waiting");
			else begin
				want = pending_results.pop_front();
				if (result.probability !== want.probability)
					report_mismatch($sformatf("probability %0d, predicted %0d",
						result.probability, want.probability));
				if (result.predicted_class !== want.predicted_class)
					report_mismatch($sformatf("class %0b, predicted %0b",
						result.predicted_class, want.predicted_class));
			end
		end
	end

	initial begin : stimulus
		int nc;
		int nf;
		int n_samples;
		int r;
		arst_n = 0;
		item_valid = 0;
		item = '0;
		cfg_valid = 0;
		cfg_index = CFG_CENTER_COUNT;
		cfg_data = '0;
		result_stall = 0;
		foreach (dist_acc[c])
			dist_acc[c] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty network: the sum is the bias alone
		add_row(row_cfg(CFG_CENTER_COUNT, 0));
		add_row(row_cfg(CFG_FEATURE_COUNT, 1));
		add_row(row_item(mk_item(CMD_SAMPLE, 0, 0, 16'h7FFF, '0), 1, 17'd32768, 1));
		add_row(row_cfg(CFG_BIAS, 32'h7FFF_FFFF));
		add_row(row_item(mk_item(CMD_SAMPLE, 31, 0, 16'h8000, '1), 1, 17'd65536, 1));
		add_row(row_cfg(CFG_BIAS, 32'h8000_0000));
		add_row(row_item(mk_item(CMD_SAMPLE, 0, 0, 16'h0000, '0), 1, 17'd0, 0));
		// ignored: unknown command, feature beyond count, feature count zero
		add_row(row_item(mk_item(CMD_UNUSED, 31, 15, 16'hFFFF, '1)));
		add_row(row_item(mk_item(CMD_SAMPLE, 0, 15, 16'h1234, '0)));
		add_row(row_cfg(CFG_FEATURE_COUNT, 0));
		add_row(row_item(mk_item(CMD_SAMPLE, 0, 0, 16'h1234, '0)));
		// one centre, extreme distance and weights
		add_row(row_cfg(CFG_CENTER_COUNT, 1));
		add_row(row_cfg(CFG_FEATURE_COUNT, 1));
		add_row(row_cfg(CFG_BIAS, 0));
		add_row(row_item(mk_item(CMD_CENTER, 0, 0, 16'h8000, '0)));
		add_row(row_item(mk_item(CMD_CENTER, 0, 1, 16'h0100, '0)));
		add_row(row_item(mk_item(CMD_WEIGHT, 0, 0, '0, 32'h7FFF_FFFF)));
		add_row(row_item(mk_item(CMD_SAMPLE, 0, 0, 16'h7FFF, '0)));
		add_row(row_item(mk_item(CMD_SAMPLE, 0, 0, 16'h8000, '0)));
		add_row(row_cfg(CFG_INV_TWO_SIGMA_SQ, 0));
		add_row(row_item(mk_item(CMD_WEIGHT, 0, 0, '0, 32'h8000_0000)));
		add_row(row_item(mk_item(CMD_SAMPLE, 0, 0, 16'h0040, '0)));
		// two features sent last index first
		add_row(row_cfg(CFG_INV_TWO_SIGMA_SQ, 32'd65536));
		add_row(row_cfg(CFG_FEATURE_COUNT, 2));
		add_row(row_item(mk_item(CMD_SAMPLE, 0, 1, 16'h0180, '0)));
		add_row(row_item(mk_item(CMD_SAMPLE, 0, 0, 16'hFF80, '0)));
		add_row(row_item(mk_item(CMD_SAMPLE, 0, 1, 16'h0100, '0)));

		foreach (steps[i]) begin
			if (steps[i].is_cfg)
				write_reg(steps[i].idx, steps[i].data);
			else
				send_item(steps[i].it, steps[i].known, steps[i].want);
		end
		items_sent = steps.size();

		// load every table entry so later samples never read an unwritten one
		for (int c = 0; c < NUM_CTR; c++) begin
			for (int f = 0; f < NUM_FEAT; f++)
				send_item(mk_item(CMD_CENTER, c, f, rand_coord(), $urandom));
			send_item(mk_item(CMD_WEIGHT, c, $urandom_range(0, 15), 16'($urandom),
				rand_weight()));
			items_sent += NUM_FEAT + 1;
		end

		while (items_sent < ITEM_TARGET) begin
			// a new setting; the idle wait also makes the sender hold until all results are in
			r = $urandom_range(0, 5);
			write_reg(CFG_CENTER_COUNT, r == 0 ? 0 : r == 1 ? 1 : r == 2 ? 32 :
				r == 3 ? $urandom_range(33, 63) : $urandom_range(1, 32));
			r = $urandom_range(0, 5);
			write_reg(CFG_FEATURE_COUNT, r == 0 ? 1 : r == 1 ? 16 :
				r == 2 ? $urandom_range(17, 31) : $urandom_range(1, 16));
			r = $urandom_range(0, 5);
			write_reg(CFG_INV_TWO_SIGMA_SQ, r == 0 ? 0 : r == 1 ? 32'hFFFF_FFFF :
				r == 2 ? $urandom_range(1, 256) : $urandom_range(1024, 1 << 20));
			r = $urandom_range(0, 5);
			write_reg(CFG_BIAS, r == 0 ? 32'h7FFF_FFFF : r == 1 ? 32'h8000_0000 :
				32'($urandom_range(0, 1 << 20) - (1 << 19)));
			calm_tx = $urandom_range(0, 3) == 0;
			calm_rx = $urandom_range(0, 3) == 0;
			nc = reg_centers > NUM_CTR ? NUM_CTR : int'(reg_centers);
			nf = reg_features > NUM_FEAT ? NUM_FEAT : int'(reg_features);
			n_samples = $urandom_range(2, 6);
			for (int s = 0; s < n_samples; s++) begin
				for (int f = 0; f < nf; f++) begin
					r = $urandom_range(0, 99);
					if (r < 4)
						send_item(mk_item(CMD_UNUSED, $urandom_range(0, 31),
							$urandom_range(0, 15), 16'($urandom), $urandom));
					else if (r < 7 && nf < NUM_FEAT)
						send_item(mk_item(CMD_SAMPLE, 0, $urandom_range(nf, 15),
							16'($urandom), '0));
					else if (r < 10) begin
						send_item(mk_item(CMD_WEIGHT, $urandom_range(0, 31), 0, '0,
							rand_weight()));
						items_sent++;
					end else if (r < 13) begin
						send_item(mk_item(CMD_CENTER, $urandom_range(0, 31),
							$urandom_range(0, 15), rand_coord(), '0));
						items_sent++;
					end
					// occasionally out of order: a random index in place of the next one
					send_item(mk_item(CMD_SAMPLE, $urandom_range(0, 31),
						$urandom_range(0, 19) == 0 ? $urandom_range(0, nf - 1) : f,
						rand_coord(), $urandom));
					items_sent++;
				end
			end
		end

		settle();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
